### sv/fpbcd_pkg.sv
package fpbcd_pkg;

  localparam int unsigned VALUE_W      = 64;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OUT_BYTES    = 5;
  localparam int unsigned BYTE_COUNT_W = 3;

  typedef struct packed {
    logic load;
    logic dabble;
    logic emit;
    logic emit_last;
    logic frac;
  } ctrl_cmd_t;

endpackage

### sv/fpbcd_ctrl.sv
module fpbcd_ctrl #(
  parameter int unsigned INT_BITS   = 32,
  parameter int unsigned INT_DIGITS = 10,
  parameter int unsigned FRAC_DIGS  = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output fpbcd_pkg::ctrl_cmd_t  cmd_o
);
  import fpbcd_pkg::*;

  localparam int unsigned MAX_A = (INT_BITS > INT_DIGITS) ? INT_BITS : INT_DIGITS;
  localparam int unsigned MAX_S = (MAX_A > FRAC_DIGS) ? MAX_A : FRAC_DIGS;
  localparam int unsigned SW    = (MAX_S > 1) ? $clog2(MAX_S) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EMIT,
    ST_FRAC
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   step_q;
  logic            busy_q;
  logic            valid_q;
  logic            dabble_last;
  logic            emit_last;
  logic            frac_last;

  assign dabble_last = (step_q == SW'(INT_BITS - 1));
  assign emit_last   = (step_q == SW'(INT_DIGITS - 1));
  assign frac_last   = (step_q == SW'(FRAC_DIGS - 1));

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && start_i;
    cmd_o.dabble    = (state_q == ST_DABBLE);
    cmd_o.emit      = (state_q == ST_EMIT);
    cmd_o.emit_last = emit_last;
    cmd_o.frac      = (state_q == ST_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_DABBLE;
            step_q  <= '0;
            busy_q  <= 1'b1;
          end
        end
        ST_DABBLE: begin
          if (dabble_last) begin
            state_q <= ST_EMIT;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_last) begin
            state_q <= ST_FRAC;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_FRAC: begin
          if (frac_last) begin
            state_q <= ST_IDLE;
            step_q  <= '0;
            busy_q  <= 1'b0;
            valid_q <= 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o  = busy_q;
  assign valid_o = valid_q;

endmodule

### sv/fpbcd_dp.sv
module fpbcd_dp #(
  parameter int unsigned TOTAL_DIGITS  = 10,
  parameter int unsigned FRACTION_BITS = 32,
  parameter int unsigned INT_BITS      = 32,
  parameter int unsigned INT_DIGITS    = 10
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  fpbcd_pkg::ctrl_cmd_t                               cmd_i,
  input  logic signed [fpbcd_pkg::VALUE_W-1:0]               value_i,
  output logic [fpbcd_pkg::OUT_BYTES-1:0][fpbcd_pkg::BYTE_W-1:0] bytes_o,
  output logic [fpbcd_pkg::BYTE_COUNT_W-1:0]                 byte_count_o
);
  import fpbcd_pkg::*;

  localparam int unsigned KEEP_D = (TOTAL_DIGITS < 2 * OUT_BYTES) ? TOTAL_DIGITS
                                                                  : 2 * OUT_BYTES;
  localparam int unsigned KIW    = $clog2(KEEP_D);
  localparam int unsigned CW     = $clog2(TOTAL_DIGITS + 1);
  localparam int unsigned BCD_W  = INT_DIGITS * DIGIT_W;

  logic [VALUE_W-1:0]       mag;
  logic [INT_BITS-1:0]      bin_q, bin_d;
  logic [BCD_W-1:0]         bcd_q, bcd_d, bcd_adj;
  logic [FRACTION_BITS-1:0] frac_q, frac_d;
  logic [FRACTION_BITS+3:0] frac_x10;
  logic [DIGIT_W-1:0]       dig_q [KEEP_D];
  logic [CW-1:0]            kept_q;
  logic                     started_q;
  logic                     started_d;
  logic [DIGIT_W-1:0]       top_digit;
  logic                     put;
  logic [DIGIT_W-1:0]       put_digit;
  logic [CW:0]              kept_p1;
  logic [CW:0]              half;

  assign mag = value_i[VALUE_W-1] ? (~value_i + 1'b1) : value_i;

  // add three to every digit of five or more, then shift
  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  assign frac_x10  = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);

  always_comb begin
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    frac_d    = frac_q;
    started_d = started_q;
    put       = 1'b0;
    put_digit = top_digit;
    if (cmd_i.dabble) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[INT_BITS-1]};
      bin_d = bin_q << 1;
    end else if (cmd_i.emit) begin
      bcd_d = bcd_q << DIGIT_W;
      // skip leading zeros but always keep the units digit
      if (started_q || (top_digit != '0) || cmd_i.emit_last) begin
        put       = 1'b1;
        started_d = 1'b1;
      end
    end else if (cmd_i.frac) begin
      frac_d    = frac_x10[FRACTION_BITS-1:0];
      put       = 1'b1;
      put_digit = frac_x10[FRACTION_BITS+3:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q    <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.load) begin
      kept_q    <= '0;
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
      if (put && (kept_q < CW'(TOTAL_DIGITS))) begin
        kept_q <= kept_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q  <= mag[VALUE_W-1:FRACTION_BITS];
      frac_q <= mag[FRACTION_BITS-1:0];
      bcd_q  <= '0;
      for (int i = 0; i < KEEP_D; i++) begin
        dig_q[i] <= '0;
      end
    end else begin
      bin_q  <= bin_d;
      bcd_q  <= bcd_d;
      frac_q <= frac_d;
      if (put && (kept_q < CW'(KEEP_D))) begin
        dig_q[kept_q[KIW-1:0]] <= put_digit;
      end
    end
  end

  for (genvar b = 0; b < OUT_BYTES; b++) begin : g_byte
    if (2 * b + 1 < KEEP_D) begin : g_full
      assign bytes_o[b] = {dig_q[2*b], dig_q[2*b+1]};
    end else if (2 * b < KEEP_D) begin : g_half
      assign bytes_o[b] = {dig_q[2*b], {DIGIT_W{1'b0}}};
    end else begin : g_none
      assign bytes_o[b] = '0;
    end
  end

  assign kept_p1 = {1'b0, kept_q} + 1'b1;
  assign half    = kept_p1 >> 1;
  assign byte_count_o = (half > (CW+1)'(OUT_BYTES)) ? BYTE_COUNT_W'(OUT_BYTES)
                                                    : BYTE_COUNT_W'(half);

endmodule

### sv/fixed_to_packed_bcd_top.sv
// Converts one signed fixed-point number (FRACTION_BITS fraction bits) to packed BCD:
// the integer digits of its magnitude without leading zeros, then FRACTION_DIGITS
// truncated fraction digits, the first TOTAL_DIGITS packed two per byte, high nibble
// first. An item is taken when start is high and busy is low; busy then stays high
// through a double-dabble shift for each integer bit, an emit step for each integer
// digit position of the BCD register, and a multiply-by-ten step for each fraction digit.
// At the edge that ends the last of these busy drops and valid_o goes high, for exactly
// one cycle, with the result on the byte ports; it is not held, so the receiver must
// capture it then. A new start may be given in the same cycle that valid_o is high.
module fixed_to_packed_bcd_top #(
  parameter int unsigned TOTAL_DIGITS    = 10,
  parameter int unsigned FRACTION_DIGITS = 9,
  parameter int unsigned FRACTION_BITS   = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [fpbcd_pkg::VALUE_W-1:0]  value_i,
  output logic                                  valid_o,
  output logic [fpbcd_pkg::BYTE_W-1:0]          bcd_byte_0_o,
  output logic [fpbcd_pkg::BYTE_W-1:0]          bcd_byte_1_o,
  output logic [fpbcd_pkg::BYTE_W-1:0]          bcd_byte_2_o,
  output logic [fpbcd_pkg::BYTE_W-1:0]          bcd_byte_3_o,
  output logic [fpbcd_pkg::BYTE_W-1:0]          bcd_byte_4_o,
  output logic [fpbcd_pkg::BYTE_COUNT_W-1:0]    byte_count_o
);
  import fpbcd_pkg::*;

  localparam int unsigned INT_BITS   = VALUE_W - FRACTION_BITS;
  localparam int unsigned INT_DIGITS = (INT_BITS * 30103) / 100000 + 1;

  ctrl_cmd_t                           cmd;
  logic [OUT_BYTES-1:0][BYTE_W-1:0]    bytes;

  fpbcd_ctrl #(
    .INT_BITS   (INT_BITS),
    .INT_DIGITS (INT_DIGITS),
    .FRAC_DIGS  (FRACTION_DIGITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  fpbcd_dp #(
    .TOTAL_DIGITS  (TOTAL_DIGITS),
    .FRACTION_BITS (FRACTION_BITS),
    .INT_BITS      (INT_BITS),
    .INT_DIGITS    (INT_DIGITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .bytes_o      (bytes),
    .byte_count_o (byte_count_o)
  );

  assign bcd_byte_0_o = bytes[0];
  assign bcd_byte_1_o = bytes[1];
  assign bcd_byte_2_o = bytes[2];
  assign bcd_byte_3_o = bytes[3];
  assign bcd_byte_4_o = bytes[4];

endmodule
